FILE: rtl/mbrc_pkg.sv
`timescale 1ns / 1ps

package mbrc_pkg;

  localparam int ENTRY_COUNT = 4;
  localparam int ENTRY_BYTES = 16;
  localparam int SIG_FIRST   = ENTRY_BYTES * ENTRY_COUNT;

  // byte position counts 0 .. SIG_FIRST+1
  localparam int POS_W = $clog2(SIG_FIRST + 2);
  // entry slot taken from the position above the byte offset
  localparam int HI_W  = POS_W - 4;

  localparam logic [7:0] SIG_LOW_BYTE    = 8'h55;
  localparam logic [7:0] SIG_HIGH_BYTE   = 8'hAA;
  localparam logic [7:0] STATUS_ACTIVE   = 8'h80;
  localparam logic [7:0] STATUS_INACTIVE = 8'h00;
  localparam logic [7:0] KIND_EMPTY      = 8'h00;

  localparam logic [3:0] OFF_STATUS = 4'd0;
  localparam logic [3:0] OFF_KIND   = 4'd4;
  localparam logic [3:0] OFF_START0 = 4'd8;
  localparam logic [3:0] OFF_START3 = 4'd11;
  localparam logic [3:0] OFF_SIZE0  = 4'd12;
  localparam logic [3:0] OFF_LAST   = 4'd15;

  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  kind;
    logic [31:0] start;
    logic [31:0] size;
  } entry_t;

endpackage

FILE: rtl/mbrc_if.sv
`timescale 1ns / 1ps

interface mbrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       restart;

  modport source (output valid, output table_byte, output restart, input ready);
  modport sink   (input valid, input table_byte, input restart, output ready);
endinterface

interface mbrc_out_if;
  logic valid;
  logic ready;
  logic table_valid;

  modport source (output valid, output table_valid, input ready);
  modport sink   (input valid, input table_valid, output ready);
endinterface

FILE: rtl/mbrc_entry_check.sv
`timescale 1ns / 1ps

module mbrc_entry_check (
  input  mbrc_pkg::entry_t                entry,
  input  logic [mbrc_pkg::HI_W-1:0]       slot,
  input  logic [31:0]                     starts [mbrc_pkg::ENTRY_COUNT],
  input  logic [32:0]                     ends   [mbrc_pkg::ENTRY_COUNT],
  input  logic [mbrc_pkg::ENTRY_COUNT-1:0] used,
  output logic                            ok,
  output logic [32:0]                     entry_end
);
  import mbrc_pkg::*;

  logic status_ok;
  logic overlap;

  assign entry_end = {1'b0, entry.start} + {1'b0, entry.size};
  assign status_ok = (entry.status == STATUS_INACTIVE) || (entry.status == STATUS_ACTIVE);

  // range [start, end) against each earlier used entry
  always_comb begin
    overlap = 1'b0;
    for (int j = 0; j < ENTRY_COUNT; j++) begin
      if (used[j] && (HI_W'(j) < slot) &&
          ({1'b0, entry.start} < ends[j]) && ({1'b0, starts[j]} < entry_end)) begin
        overlap = 1'b1;
      end
    end
  end

  always_comb begin
    if (entry.kind == KIND_EMPTY) begin
      ok = status_ok && (entry.start == 32'd0) && (entry.size == 32'd0);
    end else begin
      ok = status_ok && (entry.start != 32'd0) && (entry.size != 32'd0) && !overlap;
    end
  end

endmodule

FILE: rtl/mbrc_top_dummy_placeholder.sv
`timescale 1ns / 1ps

// byte register stage: holds one item until the checker stage takes it
module mbrc_byte_stage (
  input  logic       clk,
  input  logic       rst,
  mbrc_in_if.sink    table_ch,
  input  logic       take,
  output logic       held,
  output logic [7:0] held_byte,
  output logic       held_restart
);

  assign table_ch.ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (table_ch.valid && table_ch.ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (table_ch.valid && table_ch.ready) begin
      held_byte    <= table_ch.table_byte;
      held_restart <= table_ch.restart;
    end
  end

  stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    held && !take |=> held && $stable(held_byte) && $stable(held_restart))
    else $error("held byte changed while stalled");

endmodule

FILE: rtl/mbr_partition_table_checker.sv
`timescale 1ns / 1ps

// mbr partition table checker
// table_ch carries the 66-byte tail of a master boot record, one byte per
// item, starting at the first partition entry; restart=1 marks byte 0 of a
// table. bytes seen before any restart mark are dropped. on the last
// signature byte one item goes out on result_ch: table_valid=1 when every
// entry passes its status, empty/used and overlap checks and the signature
// reads 0x55 0xaa. a restart in mid-table drops the partial table.
// a byte enters the byte register, and when the checker stage takes it,
// the checker stage updates its state and loads the result register.
// throughput: one byte per cycle unless result_ch stalls; the entry check
// (33-bit end sum and the four-way overlap compare) is combinational in
// the checker stage.
// when result_ch stalls with a result pending, the checker stage holds and
// the byte register fills, then table_ch.ready drops.
// reset (rst, synchronous) clears progress and waits for a restart mark.
module mbr_partition_table_checker (
  input  logic        clk,
  input  logic        rst,
  mbrc_in_if.sink     table_ch,
  mbrc_out_if.source  result_ch
);
  import mbrc_pkg::*;

  logic       held;
  logic [7:0] held_byte;
  logic       held_restart;
  logic       take;

  logic [POS_W-1:0]       pos, pos_next;
  entry_t                 cur, cur_next;
  logic [ENTRY_COUNT-1:0] earlier_used, earlier_used_next;
  logic                   still_good, still_good_next;
  logic                   first_mark_seen, first_mark_seen_next;
  logic [31:0]            earlier_starts [ENTRY_COUNT];
  logic [32:0]            earlier_ends   [ENTRY_COUNT];

  logic                   out_valid;
  logic                   out_table_valid;

  logic [POS_W-1:0]       eff_pos;
  logic                   eff_good;
  logic [ENTRY_COUNT-1:0] eff_used;
  logic                   eff_seen;
  entry_t                 upd;
  logic [3:0]             off;
  logic [HI_W-1:0]        slot;
  logic                   in_entries;
  logic                   check_now;
  logic                   result_now;
  logic                   entry_ok;
  logic [32:0]            entry_end;

  mbrc_byte_stage u_byte_stage (
    .clk          (clk),
    .rst          (rst),
    .table_ch     (table_ch),
    .take         (take),
    .held         (held),
    .held_byte    (held_byte),
    .held_restart (held_restart)
  );

  assign take = held && (!out_valid || result_ch.ready);

  // state as seen after a restart mark clears progress
  always_comb begin
    eff_pos  = held_restart ? '0 : pos;
    eff_good = held_restart ? 1'b1 : still_good;
    eff_used = held_restart ? '0 : earlier_used;
    eff_seen = held_restart || first_mark_seen;
    upd      = held_restart ? '0 : cur;
    off      = eff_pos[3:0];
    slot     = eff_pos[POS_W-1:4];
    in_entries = eff_pos < POS_W'(SIG_FIRST);
    if (in_entries) begin
      case (off) inside
        OFF_STATUS:              upd.status = held_byte;
        OFF_KIND:                upd.kind   = held_byte;
        [OFF_START0:OFF_START3]: upd.start[{off[1:0], 3'b000} +: 8] = held_byte;
        [OFF_SIZE0:OFF_LAST]:    upd.size[{off[1:0], 3'b000} +: 8]  = held_byte;
        default:                 ;
      endcase
    end
    check_now  = take && eff_seen && in_entries && (off == OFF_LAST);
    result_now = take && eff_seen && (eff_pos > POS_W'(SIG_FIRST));
  end

  mbrc_entry_check u_entry_check (
    .entry     (upd),
    .slot      (slot),
    .starts    (earlier_starts),
    .ends      (earlier_ends),
    .used      (eff_used),
    .ok        (entry_ok),
    .entry_end (entry_end)
  );

  always_comb begin
    pos_next             = pos;
    cur_next             = cur;
    earlier_used_next    = earlier_used;
    still_good_next      = still_good;
    first_mark_seen_next = first_mark_seen;
    if (take && eff_seen) begin
      pos_next             = eff_pos + POS_W'(1);
      cur_next             = upd;
      earlier_used_next    = eff_used;
      still_good_next      = eff_good;
      first_mark_seen_next = 1'b1;
      if (in_entries) begin
        if (off == OFF_LAST) begin
          still_good_next = eff_good && entry_ok;
          for (int j = 0; j < ENTRY_COUNT; j++) begin
            if (slot == HI_W'(j)) begin
              earlier_used_next[j] = (upd.kind != KIND_EMPTY);
            end
          end
        end
      end else if (eff_pos == POS_W'(SIG_FIRST)) begin
        still_good_next = eff_good && (held_byte == SIG_LOW_BYTE);
      end else begin
        // result byte: back to waiting for a restart mark
        pos_next             = '0;
        cur_next             = '0;
        earlier_used_next    = '0;
        still_good_next      = 1'b1;
        first_mark_seen_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos             <= '0;
      cur             <= '0;
      earlier_used    <= '0;
      still_good      <= 1'b1;
      first_mark_seen <= 1'b0;
    end else begin
      pos             <= pos_next;
      cur             <= cur_next;
      earlier_used    <= earlier_used_next;
      still_good      <= still_good_next;
      first_mark_seen <= first_mark_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (check_now) begin
      for (int j = 0; j < ENTRY_COUNT; j++) begin
        if (slot == HI_W'(j)) begin
          earlier_starts[j] <= upd.start;
          earlier_ends[j]   <= entry_end;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_now) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_now) begin
      out_table_valid <= eff_good && (held_byte == SIG_HIGH_BYTE);
    end
  end

  assign result_ch.valid       = out_valid;
  assign result_ch.table_valid = out_table_valid;

  pos_in_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(SIG_FIRST + 1))
    else $error("byte position past the signature");

  idle_until_mark: assert property (@(posedge clk) disable iff (rst)
    !first_mark_seen |-> (pos == '0) && (earlier_used == '0))
    else $error("progress without a restart mark");

  result_clears: assert property (@(posedge clk) disable iff (rst)
    result_now |=> out_valid && !first_mark_seen && (pos == '0) && still_good)
    else $error("progress not cleared after result");

  no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_ch.ready |-> !result_now)
    else $error("result overwritten while stalled");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mbrc_pkg::*;

  localparam int TABLE_LEN    = SIG_FIRST + 2;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int GAP_MAX      = 40;

  logic clk;
  logic rst;

  mbrc_in_if  table_ch ();
  mbrc_out_if result_ch ();

  mbr_partition_table_checker u_top (
    .clk       (clk),
    .rst       (rst),
    .table_ch  (table_ch),
    .result_ch (result_ch)
  );

  // table image under construction for the sender
  entry_t ents [ENTRY_COUNT];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int table_bytes    = 0;
  int errors         = 0;
  int quiet_cycles   = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  // predictor state
  int          tbl_pos;
  entry_t      cur;
  logic [31:0] seen_start [ENTRY_COUNT];
  logic [32:0] seen_end   [ENTRY_COUNT];
  bit          seen_used  [ENTRY_COUNT];
  bit          table_ok;
  bit          armed;
  bit          expected_verdicts [$];
  bit          verdict;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_progress();
    int i;
    tbl_pos = 0;
    cur = '0;
    for (i = 0; i < ENTRY_COUNT; i++) seen_used[i] = 1'b0;
    table_ok = 1'b1;
  endfunction

  function automatic void judge_entry(int slot);
    logic [32:0] stop;
    int j;
    stop = {1'b0, cur.start} + {1'b0, cur.size};
    if (cur.status != STATUS_INACTIVE && cur.status != STATUS_ACTIVE) table_ok = 1'b0;
    if (cur.kind == KIND_EMPTY) begin
      if (cur.start != 0 || cur.size != 0) table_ok = 1'b0;
    end else begin
      if (cur.start == 0 || cur.size == 0) table_ok = 1'b0;
      for (j = 0; j < slot; j++) begin
        if (seen_used[j] && {1'b0, cur.start} < seen_end[j] &&
            {1'b0, seen_start[j]} < stop) table_ok = 1'b0;
      end
    end
    seen_start[slot] = cur.start;
    seen_end[slot]   = stop;
    seen_used[slot]  = (cur.kind != KIND_EMPTY);
  endfunction

  function automatic void track_table_byte(logic [7:0] b, logic r);
    logic [3:0] off;
    int sh;
    if (r) begin
      clear_progress();
      armed = 1'b1;
    end
    if (!armed) return;
    if (tbl_pos < SIG_FIRST) begin
      off = 4'(tbl_pos % ENTRY_BYTES);
      if (off == OFF_STATUS) begin
        cur.status = b;
      end else if (off == OFF_KIND) begin
        cur.kind = b;
      end else if (off >= OFF_START0 && off <= OFF_START3) begin
        sh = (int'(off) - int'(OFF_START0)) * 8;
        cur.start[sh +: 8] = b;
      end else if (off >= OFF_SIZE0) begin
        sh = (int'(off) - int'(OFF_SIZE0)) * 8;
        cur.size[sh +: 8] = b;
      end
      if (off == OFF_LAST) judge_entry(tbl_pos / ENTRY_BYTES);
    end else if (tbl_pos == SIG_FIRST) begin
      if (b != SIG_LOW_BYTE) table_ok = 1'b0;
    end else begin
      expected_verdicts.push_back(table_ok && b == SIG_HIGH_BYTE);
      clear_progress();
      armed = 1'b0;
      return;
    end
    tbl_pos++;
  endfunction

  always @(posedge clk) begin
    if (!rst && table_ch.valid && table_ch.ready)
      track_table_byte(table_ch.table_byte, table_ch.restart);
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: table_valid=%0b", result_ch.table_valid);
        errors++;
      end else begin
        verdict = expected_verdicts.pop_front();
        if (result_ch.table_valid !== verdict) begin
          $error("table_valid: expected %0b, actual %0b", verdict, result_ch.table_valid);
          errors++;
        end
      end
    end
  end

  // result side: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (table_ch.valid && table_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
        $display("** mbr_partition_table_checker: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic r);
    int gap;
    gap = 0;
    while (gap < GAP_MAX && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      table_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    table_ch.valid      <= 1'b1;
    table_ch.table_byte <= b;
    table_ch.restart    <= r;
    do @(posedge clk); while (!table_ch.ready);
  endtask

  // sends the first count bytes of the table in ents, restart on byte 0
  task automatic send_table(input logic [7:0] sig_lo, input logic [7:0] sig_hi,
                            input int count);
    logic [7:0] b;
    logic [3:0] off;
    entry_t e;
    int i;
    for (i = 0; i < count; i++) begin
      if (i == SIG_FIRST) begin
        b = sig_lo;
      end else if (i > SIG_FIRST) begin
        b = sig_hi;
      end else begin
        e = ents[i / ENTRY_BYTES];
        off = 4'(i % ENTRY_BYTES);
        if (off == OFF_STATUS) b = e.status;
        else if (off == OFF_KIND) b = e.kind;
        else if (off >= OFF_START0 && off <= OFF_START3)
          b = e.start[(int'(off) - int'(OFF_START0)) * 8 +: 8];
        else if (off >= OFF_SIZE0)
          b = e.size[(int'(off) - int'(OFF_SIZE0)) * 8 +: 8];
        else b = 8'($urandom);
      end
      send_byte(b, i == 0);
    end
    table_bytes += count;
  endtask

  task automatic send_full();
    send_table(SIG_LOW_BYTE, SIG_HIGH_BYTE, TABLE_LEN);
  endtask

  function automatic void clear_entries();
    int i;
    for (i = 0; i < ENTRY_COUNT; i++) ents[i] = '0;
  endfunction

  function automatic void set_entry(int slot, logic [7:0] status, logic [7:0] kind,
                                    logic [31:0] start, logic [31:0] size);
    ents[slot].status = status;
    ents[slot].kind   = kind;
    ents[slot].start  = start;
    ents[slot].size   = size;
  endfunction

  function automatic void good_entries();
    clear_entries();
    set_entry(0, STATUS_ACTIVE, 8'h07, 32'd2048, 32'h0010_0000);
    set_entry(2, STATUS_INACTIVE, 8'h0C, 32'h0010_0800, 32'h0200_0000);
  endfunction

  task automatic test_ignored_bytes();
    send_byte(SIG_LOW_BYTE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    good_entries();
    send_full();
    // no restart mark after the result: dropped
    send_byte(8'hA5, 1'b0);
    send_byte(SIG_HIGH_BYTE, 1'b0);
    send_full();
  endtask

  task automatic test_good_tables();
    clear_entries();
    set_entry(0, STATUS_ACTIVE, 8'h07, 32'd2048, 32'h1000);
    // touches the end of the entry before it
    set_entry(1, STATUS_INACTIVE, 8'h83, 32'd2048 + 32'h1000, 32'hFFFE_0000);
    send_full();
    clear_entries();
    send_full();
    clear_entries();
    set_entry(3, STATUS_INACTIVE, 8'h01, 32'h0000_0001, 32'h3FFF_FFFF);
    set_entry(2, STATUS_ACTIVE, 8'hFF, 32'h4000_0000, 32'h4000_0000);
    set_entry(1, STATUS_INACTIVE, 8'h80, 32'h8000_0000, 32'h4000_0000);
    set_entry(0, STATUS_INACTIVE, 8'h7F, 32'hC000_0000, 32'h4000_0000);
    send_full();
  endtask

  task automatic test_status_rule();
    clear_entries();
    set_entry(0, 8'h01, 8'h0C, 32'd100, 32'd50);
    send_full();
    clear_entries();
    ents[2].status = 8'hFF;
    send_full();
    clear_entries();
    set_entry(3, 8'h7F, 8'h83, 32'd9, 32'd9);
    send_full();
  endtask

  task automatic test_empty_rule();
    clear_entries();
    ents[1].start = 32'd5;
    send_full();
    clear_entries();
    ents[3].size = 32'h8000_0000;
    send_full();
  endtask

  task automatic test_used_rule();
    clear_entries();
    set_entry(0, STATUS_ACTIVE, 8'h83, 32'd0, 32'd10);
    send_full();
    clear_entries();
    set_entry(2, STATUS_INACTIVE, 8'hFF, 32'hFFFF_FFFF, 32'd0);
    send_full();
  endtask

  task automatic test_overlap_rule();
    clear_entries();
    set_entry(0, STATUS_ACTIVE, 8'h83, 32'd1000, 32'd100);
    set_entry(1, STATUS_INACTIVE, 8'h83, 32'd1099, 32'd1);
    send_full();
    clear_entries();
    set_entry(0, STATUS_ACTIVE, 8'hEE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_full();
    // end of the first range needs the 33rd bit
    clear_entries();
    set_entry(0, STATUS_ACTIVE, 8'h0B, 32'hFFFF_FFFE, 32'd2);
    set_entry(3, STATUS_INACTIVE, 8'h0B, 32'hFFFF_FFFF, 32'd1);
    send_full();
    // later range encloses an earlier one
    clear_entries();
    set_entry(1, STATUS_INACTIVE, 8'h05, 32'd500, 32'd10);
    set_entry(3, STATUS_INACTIVE, 8'h05, 32'd1, 32'hFFFF_FFFF);
    send_full();
  endtask

  task automatic test_signature();
    good_entries();
    send_table(8'h54, SIG_HIGH_BYTE, TABLE_LEN);
    send_table(SIG_LOW_BYTE, 8'h2A, TABLE_LEN);
    send_table(SIG_HIGH_BYTE, SIG_LOW_BYTE, TABLE_LEN);
  endtask

  task automatic test_restart_mid_table();
    good_entries();
    send_table(SIG_LOW_BYTE, SIG_HIGH_BYTE, 40);
    send_table(SIG_LOW_BYTE, SIG_HIGH_BYTE, TABLE_LEN - 1);
    send_full();
  endtask

  task automatic make_random_table();
    logic [32:0] next_free;
    logic [31:0] p_start [ENTRY_COUNT];
    logic [31:0] p_size  [ENTRY_COUNT];
    int n_placed, mode, k, i;
    bit clean;
    entry_t e;
    clean = 1'($urandom_range(1));
    next_free = 33'd1 + $urandom_range(0, 4096);
    n_placed = 0;
    for (i = 0; i < ENTRY_COUNT; i++) begin
      mode = clean ? $urandom_range(0, 15) : $urandom_range(0, 19);
      e = '0;
      e.status = $urandom_range(1) ? STATUS_ACTIVE : STATUS_INACTIVE;
      if (mode <= 5) begin
        e.kind = KIND_EMPTY;
      end else if (mode <= 15) begin
        e.kind = 8'($urandom_range(1, 255));
        if ($urandom_range(3) != 0) next_free = next_free + $urandom_range(1, 1 << 20);
        e.start = next_free[31:0];
        e.size = $urandom_range(1) ? $urandom_range(1, 16'hFFFF) :
                                     $urandom_range(1, 32'h3F00_0000);
        next_free = next_free + e.size;
        p_start[n_placed] = e.start;
        p_size[n_placed]  = e.size;
        n_placed++;
      end else if (mode == 16) begin
        e.kind = KIND_EMPTY;
        if ($urandom_range(1)) e.start = $urandom;
        else e.size = $urandom;
      end else if (mode == 17) begin
        e.kind = 8'($urandom_range(1, 255));
        if ($urandom_range(1)) begin
          e.size = $urandom_range(1, 32'hFFFF_FFFF);
        end else begin
          e.start = next_free[31:0];
        end
      end else if (mode == 18 && n_placed != 0) begin
        k = $urandom_range(0, n_placed - 1);
        e.kind = 8'($urandom_range(1, 255));
        e.start = p_start[k] + ($urandom % p_size[k]);
        e.size = $urandom_range(1) ? $urandom_range(1, 16'hFFFF) :
                                     $urandom_range(1, 32'hFFFF_FFFF);
      end else begin
        e.status = 8'($urandom);
        e.kind   = 8'($urandom);
        e.start  = $urandom;
        e.size   = $urandom;
      end
      if (!clean && $urandom_range(19) == 0) e.status = 8'($urandom);
      ents[i] = e;
    end
    // placement order in the table need not follow address order
    if ($urandom_range(2) == 0) begin
      for (i = 0; i < ENTRY_COUNT / 2; i++) begin
        e = ents[i];
        ents[i] = ents[ENTRY_COUNT - 1 - i];
        ents[ENTRY_COUNT - 1 - i] = e;
      end
    end
  endtask

  task automatic test_random_tables(input int send_pct, input int stall_pct, input int quota);
    logic [7:0] sig_lo, sig_hi;
    int stop_at, n, i;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    stop_at = table_bytes + quota;
    while (table_bytes < stop_at) begin
      make_random_table();
      sig_lo = ($urandom_range(15) == 0) ? 8'($urandom) : SIG_LOW_BYTE;
      sig_hi = ($urandom_range(15) == 0) ? 8'($urandom) : SIG_HIGH_BYTE;
      if ($urandom_range(7) == 0) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
      end
      if ($urandom_range(7) == 0) send_table(sig_lo, sig_hi, $urandom_range(1, TABLE_LEN - 1));
      send_table(sig_lo, sig_hi, TABLE_LEN);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asked++;
    good_entries();
    send_full();
    test_random_tables(0, 0, TABLE_LEN);
  endtask

  initial begin
    rst = 1'b1;
    table_ch.valid      = 1'b0;
    table_ch.table_byte = 8'h00;
    table_ch.restart    = 1'b0;
    clear_progress();
    armed = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_ignored_bytes();
    test_good_tables();
    test_status_rule();
    test_empty_rule();
    test_used_rule();
    test_overlap_rule();
    test_signature();
    test_restart_mid_table();

    test_random_tables(0, 0, TABLE_LEN);
    test_random_tables(81, 0, TABLE_LEN);
    test_random_tables(0, 81, TABLE_LEN);
    test_random_tables(22, 22, TABLE_LEN);
    test_backpressure();

    table_ch.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** mbr_partition_table_checker: PASSED **");
    end else begin
      $display("** mbr_partition_table_checker: FAILED **");
    end
    $finish;
  end

endmodule
